### hdl/rc5_pkg.sv
// Shared types, constants and helper functions for the RC5 block cipher.
// No dependencies; the front end, queue, engine, top level and bench refer to it.
package rc5_pkg;

  localparam int ROUNDS_DEF        = 12;
  localparam int MAX_KEY_WORDS_DEF = 16;
  localparam int CMD_QUEUE_DEPTH   = 2;

  localparam logic [31:0] MAGIC_P = 32'hb7e15163;
  localparam logic [31:0] MAGIC_Q = 32'h9e3779b9;
  localparam logic [4:0]  MIX_ROT = 5'd3;

  typedef enum logic [1:0] {
    REQ_KEY   = 2'd0,
    REQ_ENC   = 2'd1,
    REQ_DEC   = 2'd2,
    REQ_SHORT = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    OP_KEY_BYTE,
    OP_KEY_LAST,
    OP_ENC,
    OP_DEC,
    OP_SHORT
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_KEY   = 2'd1,
    STAT_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_INIT,
    BS_MIX_RD,
    BS_MIX_A,
    BS_MIX_B,
    BS_RUN,
    BS_SHORT,
    BS_DONE
  } back_state_e;

  // One classified command as it travels from the front end to the engine.
  typedef struct packed {
    op_e         op;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [7:0]  data_byte;
    logic [2:0]  short_index;
  } cmd_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] t;
    t = {x, x} << n;
    return t[63:32];
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] t;
    t = {x, x} >> n;
    return t[31:0];
  endfunction

endpackage

### hdl/rc5_req_if.sv
// Request channel of the RC5 block cipher: valid/ready plus the request fields.
// No dependencies.
interface rc5_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  key_byte;
  logic        key_last;
  logic [31:0] word_a;
  logic [31:0] word_b;
  logic [7:0]  short_byte;
  logic [2:0]  short_index;

  modport source (
    output valid, req_type, key_byte, key_last, word_a, word_b, short_byte, short_index,
    input  ready
  );

  modport sink (
    input  valid, req_type, key_byte, key_last, word_a, word_b, short_byte, short_index,
    output ready
  );
endinterface

### hdl/rc5_rsp_if.sv
// Response channel of the RC5 block cipher: valid/ready plus the result fields.
// No dependencies.
interface rc5_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_a;
  logic [31:0] out_b;
  logic [7:0]  out_byte;
  logic [1:0]  status;

  modport source (
    output valid, out_a, out_b, out_byte, status,
    input  ready
  );

  modport sink (
    input  valid, out_a, out_b, out_byte, status,
    output ready
  );
endinterface

### hdl/rc5_front.sv
// Front end: takes request transfers and turns them into classified commands.
// Depends on rc5_pkg and rc5_req_if.
module rc5_front (
  rc5_req_if.sink        req_i,
  output logic           push_valid_o,
  input  logic           push_ready_i,
  output rc5_pkg::cmd_t  push_cmd_o
);

  always_comb begin
    push_cmd_o             = '0;
    push_cmd_o.word_a      = req_i.word_a;
    push_cmd_o.word_b      = req_i.word_b;
    push_cmd_o.short_index = req_i.short_index;
    unique case (rc5_pkg::req_type_e'(req_i.req_type))
      rc5_pkg::REQ_KEY: begin
        if (req_i.key_last) begin
          push_cmd_o.op = rc5_pkg::OP_KEY_LAST;
        end else begin
          push_cmd_o.op = rc5_pkg::OP_KEY_BYTE;
        end
        push_cmd_o.data_byte = req_i.key_byte;
      end
      rc5_pkg::REQ_ENC: begin
        push_cmd_o.op = rc5_pkg::OP_ENC;
      end
      rc5_pkg::REQ_DEC: begin
        push_cmd_o.op = rc5_pkg::OP_DEC;
      end
      rc5_pkg::REQ_SHORT: begin
        push_cmd_o.op        = rc5_pkg::OP_SHORT;
        push_cmd_o.data_byte = req_i.short_byte;
      end
      default: begin
        push_cmd_o.op = rc5_pkg::OP_ENC;
      end
    endcase
  end

  assign push_valid_o = req_i.valid;
  assign req_i.ready  = push_ready_i;

endmodule

### hdl/rc5_cmd_queue.sv
// Short command queue between the front end and the cipher engine.
// Depends on rc5_pkg for the command type and the queue depth.
module rc5_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  rc5_pkg::cmd_t  push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output rc5_pkg::cmd_t  pop_cmd_o
);

  localparam int Depth = rc5_pkg::CMD_QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  rc5_pkg::cmd_t entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (push && !pop) begin
      count_d = CntW'(count_q + 1'b1);
    end else if (pop && !push) begin
      count_d = CntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

### hdl/rc5_back.sv
// Cipher engine: key loading, key schedule, block rounds and the short-message path.
// Depends on rc5_pkg and rc5_rsp_if; holds the expanded table and key word memories.
module rc5_back #(
  parameter int ROUNDS        = rc5_pkg::ROUNDS_DEF,
  parameter int MAX_KEY_WORDS = rc5_pkg::MAX_KEY_WORDS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  rc5_pkg::cmd_t  cmd_i,
  rc5_rsp_if.source      rsp_o
);

  localparam int TableWords = 2 * ROUNDS + 2;
  localparam int TabAw      = $clog2(TableWords);
  localparam int KeyAw      = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
  localparam int KeyBytes   = 4 * MAX_KEY_WORDS;
  localparam int CntW       = $clog2(KeyBytes + 1);
  localparam int NlW        = $clog2(MAX_KEY_WORDS + 1);
  localparam int MixMax     = 3 * ((TableWords > MAX_KEY_WORDS) ? TableWords : MAX_KEY_WORDS);
  localparam int StepW      = $clog2(MixMax + 1);
  localparam int IdxW       = (TabAw > 3) ? TabAw + 1 : 4;

  // Memories.
  logic [31:0] tab_mem [TableWords];
  logic [31:0] key_mem [MAX_KEY_WORDS];
  logic [31:0] tab_rdata_q, key_rdata_q;
  logic             tab_we, tab_re, key_we, key_re;
  logic [TabAw-1:0] tab_waddr, tab_raddr;
  logic [KeyAw-1:0] key_waddr, key_raddr;
  logic [31:0]      tab_wdata, key_wdata;

  // Control and datapath registers.
  rc5_pkg::back_state_e state_q, state_d;
  logic              key_valid_q, key_valid_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [31:0]       acc_q, acc_d;
  logic [31:0]       a_q, a_d, b_q, b_d;
  logic [7:0]        byte_q, byte_d;
  logic [TabAw-1:0]  ti_q, ti_d;
  logic [KeyAw-1:0]  ki_q, ki_d;
  logic [KeyAw-1:0]  kimax_q, kimax_d;
  logic [StepW-1:0]  step_q, step_d;
  logic              dec_q, dec_d;

  logic              rsp_valid_q, rsp_valid_d;
  logic [31:0]       rsp_a_q, rsp_a_d, rsp_b_q, rsp_b_d;
  logic [7:0]        rsp_byte_q, rsp_byte_d;
  rc5_pkg::status_e  rsp_status_q, rsp_status_d;

  logic              slot_free, pop;
  logic              overflow;
  logic [31:0]       acc_new;
  logic [CntW-1:0]   cnt_after;
  logic [CntW:0]     nl_sum;
  logic [NlW-1:0]    nl_new;
  logic [IdxW-1:0]   idx_ext, idx_mod;
  logic [31:0]       mix_sum, ab_sum;
  logic              odd_word, first_pair;

  assign slot_free   = !rsp_valid_q || rsp_o.ready;
  assign cmd_ready_o = (state_q == rc5_pkg::BS_IDLE) && slot_free;
  assign pop         = cmd_valid_i && cmd_ready_o;

  assign overflow   = (cnt_q >= CntW'(KeyBytes));
  assign acc_new    = acc_q | ({24'd0, cmd_i.data_byte} << {cnt_q[1:0], 3'b000});
  assign cnt_after  = overflow ? cnt_q : CntW'(cnt_q + 1'b1);
  assign nl_sum     = {1'b0, cnt_after} + (CntW + 1)'(3);
  assign nl_new     = NlW'(nl_sum >> 2);
  assign idx_ext    = IdxW'(cmd_i.short_index);
  assign idx_mod    = (idx_ext >= IdxW'(TableWords)) ? IdxW'(idx_ext - IdxW'(TableWords))
                                                     : idx_ext;
  assign ab_sum     = a_q + b_q;
  assign odd_word   = ti_q[0];
  assign first_pair = (ti_q[TabAw-1:1] == '0);

  always_comb begin
    state_d      = state_q;
    key_valid_d  = key_valid_q;
    cnt_d        = cnt_q;
    acc_d        = acc_q;
    a_d          = a_q;
    b_d          = b_q;
    byte_d       = byte_q;
    ti_d         = ti_q;
    ki_d         = ki_q;
    kimax_d      = kimax_q;
    step_d       = step_q;
    dec_d        = dec_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_a_d      = rsp_a_q;
    rsp_b_d      = rsp_b_q;
    rsp_byte_d   = rsp_byte_q;
    rsp_status_d = rsp_status_q;
    tab_we       = 1'b0;
    tab_re       = 1'b0;
    tab_waddr    = ti_q;
    tab_raddr    = ti_q;
    tab_wdata    = a_q;
    key_we       = 1'b0;
    key_re       = 1'b0;
    key_waddr    = ki_q;
    key_raddr    = ki_q;
    key_wdata    = b_q;
    mix_sum      = '0;

    unique case (state_q)
      rc5_pkg::BS_IDLE: begin
        if (pop) begin
          unique case (cmd_i.op)
            rc5_pkg::OP_KEY_BYTE, rc5_pkg::OP_KEY_LAST: begin
              rsp_valid_d  = 1'b1;
              rsp_a_d      = '0;
              rsp_b_d      = '0;
              rsp_byte_d   = '0;
              rsp_status_d = rc5_pkg::STAT_OK;
              if (!overflow) begin
                cnt_d = cnt_after;
                if (cnt_q[1:0] == 2'd3 || cmd_i.op == rc5_pkg::OP_KEY_LAST) begin
                  key_we    = 1'b1;
                  key_waddr = cnt_q[KeyAw+1:2];
                  key_wdata = acc_new;
                  acc_d     = '0;
                end else begin
                  acc_d = acc_new;
                end
              end else begin
                rsp_status_d = rc5_pkg::STAT_OVERFLOW;
              end
              if (cmd_i.op == rc5_pkg::OP_KEY_LAST) begin
                cnt_d   = '0;
                acc_d   = '0;
                a_d     = rc5_pkg::MAGIC_P;
                ti_d    = '0;
                kimax_d = KeyAw'(nl_new - 1'b1);
                step_d  = (int'(nl_new) > TableWords) ? StepW'(3 * int'(nl_new) - 1)
                                                      : StepW'(3 * TableWords - 1);
                state_d = rc5_pkg::BS_INIT;
              end
            end
            rc5_pkg::OP_ENC, rc5_pkg::OP_DEC, rc5_pkg::OP_SHORT: begin
              if (!key_valid_q) begin
                rsp_valid_d  = 1'b1;
                rsp_a_d      = '0;
                rsp_b_d      = '0;
                rsp_byte_d   = '0;
                rsp_status_d = rc5_pkg::STAT_NO_KEY;
              end else if (cmd_i.op == rc5_pkg::OP_SHORT) begin
                a_d       = '0;
                b_d       = '0;
                byte_d    = cmd_i.data_byte;
                tab_re    = 1'b1;
                tab_raddr = idx_mod[TabAw-1:0];
                state_d   = rc5_pkg::BS_SHORT;
              end else begin
                a_d       = cmd_i.word_a;
                b_d       = cmd_i.word_b;
                byte_d    = '0;
                dec_d     = (cmd_i.op == rc5_pkg::OP_DEC);
                ti_d      = (cmd_i.op == rc5_pkg::OP_DEC) ? TabAw'(TableWords - 1) : '0;
                tab_re    = 1'b1;
                tab_raddr = ti_d;
                state_d   = rc5_pkg::BS_RUN;
              end
            end
            default: begin
              state_d = rc5_pkg::BS_IDLE;
            end
          endcase
        end
      end

      rc5_pkg::BS_INIT: begin
        tab_we    = 1'b1;
        tab_waddr = ti_q;
        tab_wdata = a_q;
        if (ti_q == TabAw'(TableWords - 1)) begin
          a_d     = '0;
          b_d     = '0;
          ti_d    = '0;
          ki_d    = '0;
          state_d = rc5_pkg::BS_MIX_RD;
        end else begin
          a_d  = a_q + rc5_pkg::MAGIC_Q;
          ti_d = TabAw'(ti_q + 1'b1);
        end
      end

      rc5_pkg::BS_MIX_RD: begin
        tab_re  = 1'b1;
        key_re  = 1'b1;
        state_d = rc5_pkg::BS_MIX_A;
      end

      rc5_pkg::BS_MIX_A: begin
        mix_sum   = tab_rdata_q + ab_sum;
        a_d       = rc5_pkg::rotl32(mix_sum, rc5_pkg::MIX_ROT);
        tab_we    = 1'b1;
        tab_wdata = a_d;
        state_d   = rc5_pkg::BS_MIX_B;
      end

      rc5_pkg::BS_MIX_B: begin
        mix_sum   = key_rdata_q + ab_sum;
        b_d       = rc5_pkg::rotl32(mix_sum, ab_sum[4:0]);
        key_we    = 1'b1;
        key_wdata = b_d;
        ti_d      = (ti_q == TabAw'(TableWords - 1)) ? '0 : TabAw'(ti_q + 1'b1);
        ki_d      = (ki_q == kimax_q) ? '0 : KeyAw'(ki_q + 1'b1);
        if (step_q == '0) begin
          key_valid_d = 1'b1;
          state_d     = rc5_pkg::BS_IDLE;
        end else begin
          step_d  = StepW'(step_q - 1'b1);
          state_d = rc5_pkg::BS_MIX_RD;
        end
      end

      rc5_pkg::BS_RUN: begin
        // The table word for position ti_q is in tab_rdata_q: even positions
        // update word A, odd positions update word B.
        if (!dec_q) begin
          if (!odd_word) begin
            a_d = first_pair ? a_q + tab_rdata_q
                             : rc5_pkg::rotl32(a_q ^ b_q, b_q[4:0]) + tab_rdata_q;
          end else begin
            b_d = first_pair ? b_q + tab_rdata_q
                             : rc5_pkg::rotl32(b_q ^ a_q, a_q[4:0]) + tab_rdata_q;
          end
          if (ti_q == TabAw'(TableWords - 1)) begin
            state_d = rc5_pkg::BS_DONE;
          end else begin
            ti_d      = TabAw'(ti_q + 1'b1);
            tab_re    = 1'b1;
            tab_raddr = ti_d;
          end
        end else begin
          if (odd_word) begin
            b_d = first_pair ? b_q - tab_rdata_q
                             : rc5_pkg::rotr32(b_q - tab_rdata_q, a_q[4:0]) ^ a_q;
          end else begin
            a_d = first_pair ? a_q - tab_rdata_q
                             : rc5_pkg::rotr32(a_q - tab_rdata_q, b_q[4:0]) ^ b_q;
          end
          if (ti_q == '0) begin
            state_d = rc5_pkg::BS_DONE;
          end else begin
            ti_d      = TabAw'(ti_q - 1'b1);
            tab_re    = 1'b1;
            tab_raddr = ti_d;
          end
        end
      end

      rc5_pkg::BS_SHORT: begin
        byte_d  = byte_q ^ tab_rdata_q[7:0];
        state_d = rc5_pkg::BS_DONE;
      end

      rc5_pkg::BS_DONE: begin
        if (slot_free) begin
          rsp_valid_d  = 1'b1;
          rsp_a_d      = a_q;
          rsp_b_d      = b_q;
          rsp_byte_d   = byte_q;
          rsp_status_d = rc5_pkg::STAT_OK;
          state_d      = rc5_pkg::BS_IDLE;
        end
      end

      default: begin
        state_d = rc5_pkg::BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rc5_pkg::BS_IDLE;
      key_valid_q <= 1'b0;
      cnt_q       <= '0;
      acc_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      key_valid_q <= key_valid_d;
      cnt_q       <= cnt_d;
      acc_q       <= acc_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q          <= a_d;
    b_q          <= b_d;
    byte_q       <= byte_d;
    ti_q         <= ti_d;
    ki_q         <= ki_d;
    kimax_q      <= kimax_d;
    step_q       <= step_d;
    dec_q        <= dec_d;
    rsp_a_q      <= rsp_a_d;
    rsp_b_q      <= rsp_b_d;
    rsp_byte_q   <= rsp_byte_d;
    rsp_status_q <= rsp_status_d;
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= tab_wdata;
    end
    if (tab_re) begin
      tab_rdata_q <= tab_mem[tab_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    if (key_re) begin
      key_rdata_q <= key_mem[key_raddr];
    end
  end

  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.out_a    = rsp_a_q;
  assign rsp_o.out_b    = rsp_b_q;
  assign rsp_o.out_byte = rsp_byte_q;
  assign rsp_o.status   = rsp_status_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(KeyBytes))
    else $error("key byte count beyond key capacity");

  a_key_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(key_valid_q))
    else $error("key valid flag dropped");

  a_no_key_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_status_q == rc5_pkg::STAT_NO_KEY) |->
      (!key_valid_q && rsp_a_q == '0 && rsp_b_q == '0 && rsp_byte_q == '0))
    else $error("no-key response with a key loaded or nonzero data");

  a_ki_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rc5_pkg::BS_MIX_RD || state_q == rc5_pkg::BS_MIX_A ||
     state_q == rc5_pkg::BS_MIX_B) |-> (ki_q <= kimax_q))
    else $error("key word index past the loaded key length");
`endif

endmodule

### hdl/rc5_block_cipher.sv
// Top level of the RC5-32 block cipher: front end, command queue and engine.
// Depends on rc5_pkg, rc5_req_if, rc5_rsp_if, rc5_front, rc5_cmd_queue, rc5_back.
//
//   Channel | Direction | Carries
//   --------+-----------+--------------------------------------------------------
//   req_i   | in        | key byte, encrypt block, decrypt block, short-message byte
//   rsp_o   | out       | result words, result byte and status, one per request
//
// Block rounds are paced by the single read port of the expanded table: one
// half-round is done per table word. A short-message byte takes a table read, an
// XOR step and the response state; a plain key byte is done in the idle state.
// The final key byte starts the schedule: the table is seeded, then each of
// 3*max(2*ROUNDS+2, key words) mixing steps reads, updates A, then updates B.
// Reset clears only control state; there is no clearing pass. The two-entry
// queue keeps accepting requests until full while the engine works or waits on
// a stalled response; the engine takes no new command while a response waits.
module rc5_block_cipher #(
  parameter int ROUNDS        = rc5_pkg::ROUNDS_DEF,
  parameter int MAX_KEY_WORDS = rc5_pkg::MAX_KEY_WORDS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  rc5_req_if.sink   req_i,
  rc5_rsp_if.source rsp_o
);

  // Commands classified by the front end, before and after the queue.
  logic          push_valid, push_ready;
  rc5_pkg::cmd_t push_cmd;
  logic          pop_valid, pop_ready;
  rc5_pkg::cmd_t pop_cmd;

  // The front end decodes the request type into a command, folding the last-byte
  // flag into the command code and merging the two byte fields into one.
  rc5_front u_front (
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  // The queue decouples request transfers from the engine, so key bytes and
  // blocks can still arrive while the key schedule or a block is running.
  rc5_cmd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  // The engine executes commands strictly in order and owns all key state.
  rc5_back #(
    .ROUNDS        (ROUNDS),
    .MAX_KEY_WORDS (MAX_KEY_WORDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_cmd),
    .rsp_o       (rsp_o)
  );

endmodule

### bench/rc5_block_cipher_test.sv
// Self-checking testbench for rc5_block_cipher: directed and random requests
// against a behavioral RC5-32/12 predictor. Depends on rc5_pkg, rc5_req_if,
// rc5_rsp_if and the rc5_block_cipher RTL.
module rc5_block_cipher_test;
  import rc5_pkg::*;

  localparam int ROUNDS      = ROUNDS_DEF;
  localparam int KEY_WORDS   = MAX_KEY_WORDS_DEF;
  localparam int KEY_BYTES   = 4 * KEY_WORDS;
  localparam int TABLE_WORDS = 2 * ROUNDS + 2;
  localparam int RANDOM_ITEMS = 440;
  // Far above the slowest legal run.
  localparam int CYCLE_LIMIT = 400000;
  // Longest quiet stretch the block may need: a full key schedule plus margin.
  localparam int DRAIN_CYCLES = 320;
  localparam int LONG_HOLD_CYCLES = 400;

  // One request as the bench builds it. Fields unused by the request kind
  // still carry random values, which the block must ignore.
  typedef struct {
    req_type_e   kind;
    logic [7:0]  key_byte;
    logic        key_last;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [7:0]  short_byte;
    logic [2:0]  short_index;
  } cipher_req_t;

  // One response as the predictor expects it.
  typedef struct {
    logic [31:0] out_a;
    logic [31:0] out_b;
    logic [7:0]  out_byte;
    status_e     status;
  } cipher_out_t;

  logic clk_i;
  logic rst_ni;

  rc5_req_if req_if ();
  rc5_rsp_if rsp_if ();

  rc5_block_cipher DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  // Predictor state: the expanded subkey table, the key words being collected,
  // the count of key bytes held and whether any schedule has run yet.
  logic [31:0] subkeys [TABLE_WORDS];
  logic [31:0] key_acc [KEY_WORDS];
  int          key_bytes_held;
  bit          key_loaded;

  // Responses still owed by the block, oldest first.
  cipher_out_t responses_due [$];

  // Run-wide knobs and tallies.
  bit gaps_on;
  int long_hold_req;
  int fail_count;
  int items_sent;
  int results_checked;
  int keys_expanded;
  int bytes_dropped;
  int cycle_count;

  // Clock with a 12-unit period.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [31:0] rol32(input logic [31:0] x, input logic [4:0] n);
    return (n == 5'd0) ? x : ((x << n) | (x >> (6'd32 - {1'b0, n})));
  endfunction

  function automatic logic [31:0] ror32(input logic [31:0] x, input logic [4:0] n);
    return (n == 5'd0) ? x : ((x >> n) | (x << (6'd32 - {1'b0, n})));
  endfunction

  // Key schedule: seed the table from the magic constants, then mix it with
  // the collected key words over three passes of the longer of the two.
  function automatic void run_key_schedule();
    logic [31:0] lw [KEY_WORDS];
    logic [31:0] a, b, ab;
    int nl, steps, ti, ki;
    lw = key_acc;
    nl = (key_bytes_held + 3) >> 2;
    // A key always holds at least one word, even if it is all zero.
    if (nl == 0) nl = 1;
    if (nl > KEY_WORDS) nl = KEY_WORDS;
    subkeys[0] = MAGIC_P;
    for (int s = 1; s < TABLE_WORDS; s++) subkeys[s] = subkeys[s-1] + MAGIC_Q;
    steps = 3 * ((TABLE_WORDS > nl) ? TABLE_WORDS : nl);
    a = '0;
    b = '0;
    ti = 0;
    ki = 0;
    for (int s = 0; s < steps; s++) begin
      a = rol32(subkeys[ti] + a + b, MIX_ROT);
      subkeys[ti] = a;
      ab = a + b;
      b = rol32(lw[ki] + ab, ab[4:0]);
      lw[ki] = b;
      ti = (ti + 1 >= TABLE_WORDS) ? 0 : ti + 1;
      ki = (ki + 1 >= nl) ? 0 : ki + 1;
    end
    foreach (key_acc[i]) key_acc[i] = '0;
    key_bytes_held = 0;
    key_loaded = 1'b1;
    keys_expanded++;
  endfunction

  // Works out the response to one accepted request and advances the state.
  function automatic cipher_out_t compute_rc5_result(input cipher_req_t rq);
    cipher_out_t res;
    logic [31:0] a, b;
    res.out_a = '0;
    res.out_b = '0;
    res.out_byte = '0;
    res.status = STAT_OK;
    a = rq.word_a;
    b = rq.word_b;
    if (rq.kind == REQ_KEY) begin
      if (key_bytes_held < KEY_BYTES) begin
        key_acc[key_bytes_held >> 2] |= {24'd0, rq.key_byte} << (8 * (key_bytes_held % 4));
        key_bytes_held++;
      end else begin
        // Overflowing byte is dropped; a final flag on it still runs the schedule.
        res.status = STAT_OVERFLOW;
        bytes_dropped++;
      end
      if (rq.key_last) run_key_schedule();
    end else if (!key_loaded) begin
      res.status = STAT_NO_KEY;
    end else begin
      case (rq.kind)
        REQ_ENC: begin
          a = a + subkeys[0];
          b = b + subkeys[1];
          for (int i = 1; i <= ROUNDS; i++) begin
            a = rol32(a ^ b, b[4:0]) + subkeys[2*i];
            b = rol32(b ^ a, a[4:0]) + subkeys[2*i+1];
          end
          res.out_a = a;
          res.out_b = b;
        end
        REQ_DEC: begin
          for (int i = ROUNDS; i > 0; i--) begin
            b = ror32(b - subkeys[2*i+1], a[4:0]) ^ a;
            a = ror32(a - subkeys[2*i], b[4:0]) ^ b;
          end
          res.out_a = a - subkeys[0];
          res.out_b = b - subkeys[1];
        end
        default: begin
          // Short-message byte; the index wraps over the table size.
          res.out_byte = rq.short_byte ^ subkeys[int'(rq.short_index) % TABLE_WORDS][7:0];
        end
      endcase
    end
    return res;
  endfunction

  // A request with every field random; callers then set the fields that matter.
  function automatic cipher_req_t random_req();
    cipher_req_t rq;
    rq.kind        = req_type_e'($urandom_range(0, 3));
    rq.key_byte    = 8'($urandom_range(0, 255));
    rq.key_last    = 1'($urandom_range(0, 1));
    rq.word_a      = $urandom;
    rq.word_b      = $urandom;
    rq.short_byte  = 8'($urandom_range(0, 255));
    rq.short_index = 3'($urandom_range(0, 7));
    return rq;
  endfunction

  function automatic cipher_req_t key_req(input logic [7:0] kb, input logic last);
    cipher_req_t rq;
    rq = random_req();
    rq.kind = REQ_KEY;
    rq.key_byte = kb;
    rq.key_last = last;
    return rq;
  endfunction

  function automatic cipher_req_t block_req(input req_type_e kind, input logic [31:0] a,
                                            input logic [31:0] b);
    cipher_req_t rq;
    rq = random_req();
    rq.kind = kind;
    rq.word_a = a;
    rq.word_b = b;
    return rq;
  endfunction

  function automatic cipher_req_t short_req(input logic [7:0] sb, input logic [2:0] idx);
    cipher_req_t rq;
    rq = random_req();
    rq.kind = REQ_SHORT;
    rq.short_byte = sb;
    rq.short_index = idx;
    return rq;
  endfunction

  // Offers one request after a random idle gap and holds it until the transfer.
  // The expectation is pushed at the edge where the transfer happens.
  task automatic send_req(input cipher_req_t rq);
    int gap;
    gap = gaps_on ? $urandom_range(0, 9) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= rq.kind;
    req_if.key_byte    <= rq.key_byte;
    req_if.key_last    <= rq.key_last;
    req_if.word_a      <= rq.word_a;
    req_if.word_b      <= rq.word_b;
    req_if.short_byte  <= rq.short_byte;
    req_if.short_index <= rq.short_index;
    do @(posedge clk_i); while (!req_if.ready);
    responses_due.push_back(compute_rc5_result(rq));
    items_sent++;
  endtask

  // Loads a key of n bytes; bytes past the key store come back flagged.
  task automatic load_key(input int n);
    for (int i = 0; i < n; i++) send_req(key_req(8'($urandom_range(0, 255)), i == n - 1));
  endtask

  // Compares one accepted response with the oldest expectation.
  task automatic check_response();
    cipher_out_t want;
    if (responses_due.size() == 0) begin
      $display("%0t: response with nothing outstanding: a=%h b=%h byte=%h status=%0d",
               $time, rsp_if.out_a, rsp_if.out_b, rsp_if.out_byte, rsp_if.status);
      fail_count++;
    end else begin
      want = responses_due.pop_front();
      results_checked++;
      if (rsp_if.out_a !== want.out_a) begin
        $display("%0t: out_a expected %h actual %h", $time, want.out_a, rsp_if.out_a);
        fail_count++;
      end
      if (rsp_if.out_b !== want.out_b) begin
        $display("%0t: out_b expected %h actual %h", $time, want.out_b, rsp_if.out_b);
        fail_count++;
      end
      if (rsp_if.out_byte !== want.out_byte) begin
        $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, rsp_if.out_byte);
        fail_count++;
      end
      if (rsp_if.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_if.status);
        fail_count++;
      end
    end
  endtask

  // Response side: before each transfer ready stays low for a random number of
  // cycles while gaps are on, or for a long stretch when a test asks for one.
  initial begin
    int hold;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req > 0) begin
        hold = long_hold_req;
        long_hold_req = 0;
      end else begin
        hold = gaps_on ? $urandom_range(0, 9) : 0;
      end
      @(negedge clk_i);
      if (hold > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      check_response();
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d responses outstanding",
             $time, cycle_count, responses_due.size());
    $display("rc5_block_cipher verification failed");
    $finish;
  end

  // Before any key: every data request must report no key with zero data.
  task automatic test_no_key();
    send_req(block_req(REQ_ENC, 32'h0000_0000, 32'h0000_0000));
    send_req(block_req(REQ_DEC, 32'hffff_ffff, 32'hffff_ffff));
    send_req(short_req(8'hff, 3'd7));
  endtask

  // A one-byte zero key, then data at the extremes of every field.
  task automatic test_zero_key_extremes();
    send_req(key_req(8'h00, 1'b1));
    send_req(block_req(REQ_ENC, 32'h0000_0000, 32'h0000_0000));
    send_req(block_req(REQ_ENC, 32'hffff_ffff, 32'hffff_ffff));
    send_req(block_req(REQ_DEC, 32'h0000_0000, 32'hffff_ffff));
    send_req(block_req(REQ_DEC, 32'hffff_ffff, 32'h0000_0000));
    send_req(short_req(8'h00, 3'd0));
    send_req(short_req(8'hff, 3'd7));
    send_req(short_req(8'ha5, 3'd3));
  endtask

  // A new key is partly loaded; data in between must still use the old table.
  task automatic test_key_reload();
    send_req(key_req(8'hff, 1'b0));
    send_req(key_req(8'h80, 1'b0));
    send_req(block_req(REQ_ENC, 32'h1234_5678, 32'h9abc_def0));
    send_req(short_req(8'h5a, 3'd1));
    send_req(key_req(8'h01, 1'b1));
    send_req(block_req(REQ_ENC, 32'h1234_5678, 32'h9abc_def0));
    send_req(block_req(REQ_DEC, 32'h1234_5678, 32'h9abc_def0));
  endtask

  // A full 64-byte key followed by two extra bytes; both extras are dropped and
  // the final flag on the last one still starts the schedule.
  task automatic test_key_overflow();
    for (int i = 0; i < KEY_BYTES; i++) send_req(key_req(8'($urandom_range(0, 255)), 1'b0));
    send_req(key_req(8'hff, 1'b0));
    send_req(key_req(8'h00, 1'b1));
    send_req(block_req(REQ_ENC, $urandom, $urandom));
    send_req(short_req(8'($urandom_range(0, 255)), 3'd5));
  endtask

  // The receiver stops for a long stretch while requests keep coming, so the
  // queue and the response register fill and the input stalls.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    long_hold_req = LONG_HOLD_CYCLES;
    for (int i = 0; i < 24; i++) begin
      case ($urandom_range(0, 2))
        0: send_req(block_req(REQ_ENC, $urandom, $urandom));
        1: send_req(block_req(REQ_DEC, $urandom, $urandom));
        default: send_req(short_req(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7))));
      endcase
    end
    gaps_on = 1'b1;
  endtask

  // Mostly data traffic under a valid key, with occasional new keys of random
  // length: mostly short, some long, some full and some overflowing.
  task automatic test_random_traffic();
    int start, pick, len;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      // Every so often switch idling off for a stretch of back-to-back traffic.
      if ((items_sent % 40) == 0) gaps_on = ($urandom_range(0, 2) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: len = $urandom_range(1, 16);
          6, 7: len = $urandom_range(17, KEY_BYTES - 1);
          8: len = KEY_BYTES;
          default: len = $urandom_range(KEY_BYTES + 1, KEY_BYTES + 4);
        endcase
        load_key(len);
      end else if (pick < 8) begin
        // Stray request of any kind with every field random.
        send_req(random_req());
      end else if (pick < 45) begin
        send_req(block_req(REQ_ENC, $urandom, $urandom));
      end else if (pick < 80) begin
        send_req(block_req(REQ_DEC, $urandom, $urandom));
      end else begin
        send_req(short_req(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7))));
      end
    end
    gaps_on = 1'b1;
  endtask

  // Main sequence: reset once, then each test in turn, then drain and report.
  initial begin
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_KEY;
    req_if.key_byte = '0;
    req_if.key_last = 1'b0;
    req_if.word_a = '0;
    req_if.word_b = '0;
    req_if.short_byte = '0;
    req_if.short_index = '0;
    foreach (subkeys[i]) subkeys[i] = '0;
    foreach (key_acc[i]) key_acc[i] = '0;
    key_bytes_held = 0;
    key_loaded = 1'b0;
    gaps_on = 1'b1;
    long_hold_req = 0;
    fail_count = 0;
    items_sent = 0;
    results_checked = 0;
    keys_expanded = 0;
    bytes_dropped = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_no_key();
    test_zero_key_extremes();
    test_key_reload();
    test_key_overflow();
    test_backpressure();
    test_random_traffic();

    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (responses_due.size() != 0) @(negedge clk_i);
    // Quiet period: any late or spurious response is flagged by the checker.
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Sent %0d requests and checked %0d responses in %0d cycles.",
             items_sent, results_checked, cycle_count);
    $display("Ran %0d key schedules; %0d key bytes were dropped on overflow.",
             keys_expanded, bytes_dropped);
    if (fail_count == 0) begin
      $display("rc5_block_cipher verification clean");
    end else begin
      $display("rc5_block_cipher verification failed");
    end
    $finish;
  end

endmodule

### rc5_block_cipher.f
hdl/rc5_pkg.sv
hdl/rc5_req_if.sv
hdl/rc5_rsp_if.sv
hdl/rc5_front.sv
hdl/rc5_cmd_queue.sv
hdl/rc5_back.sv
hdl/rc5_block_cipher.sv
bench/rc5_block_cipher_test.sv
